// ===== rtl/core/serial_line_editor_defines.svh =====
// Assertion macros for the checker file of the line editor.
`ifndef SERIAL_LINE_EDITOR_DEFINES_SVH
`define SERIAL_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int CAP_W = 7;
  localparam int KIND_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [BYTE_W-1:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_ERASE,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_line_editor.sv =====
// Line editor for bytes received from a serial link.
// Input channel: a byte on in_rx_byte is taken at a rising edge with push high and
// full low. Result channel: while empty is low the oldest result word is on out_byte,
// out_kind (echo, line character, terminator) and out_last; pop takes it.
// Configuration: cfg_line_capacity is written at an edge with valid and ready high;
// ready is always high. Write it only while the block is idle.
// An ordinary byte or a backspace gives its echo from the output register once it has
// left the command queue, or no result at all when it is dropped. A carriage return
// first gives each held character, the line store memory being read one entry per
// character, and then its terminator.
// Up to two accepted bytes wait in the command queue while a line is emitted; full
// rises when both queue entries are occupied, so new bytes are refused without loss.
// When the receiver holds pop low the current word stays on the ports and the back end
// waits; the front still takes bytes until the queue fills.
// Synchronous reset empties the queue and the line, drops any pending result and sets
// the capacity to 64. The line store needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [sle_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [sle_pkg::BYTE_W-1:0] out_byte,
  output logic      [sle_pkg::KIND_W-1:0] out_kind,
  output logic                            out_last,
  input  wire logic                       valid,
  output logic                            ready,
  input  wire logic [sle_pkg::CAP_W-1:0]  cfg_line_capacity
);

  logic          fifo_full, cmd_wr, cmd_valid, cmd_pop;
  sle_pkg::cmd_t front_cmd, back_cmd;

  assign ready = 1'b1;

  sle_front u_front (
    .push      (push),
    .full      (full),
    .in_rx_byte(in_rx_byte),
    .fifo_full (fifo_full),
    .cmd_wr    (cmd_wr),
    .cmd       (front_cmd)
  );

  sle_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_wr),
    .wr_cmd   (front_cmd),
    .fifo_full(fifo_full),
    .rd_en    (cmd_pop),
    .rd_cmd   (back_cmd),
    .rd_valid (cmd_valid)
  );

  sle_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (valid && ready),
    .cfg_data (cfg_line_capacity),
    .cmd_valid(cmd_valid),
    .cmd      (back_cmd),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sle_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue of decoded commands between the front and the back.
module sle_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire sle_pkg::cmd_t wr_cmd,
  output logic               fifo_full,
  input  wire logic          rd_en,
  output sle_pkg::cmd_t      rd_cmd,
  output logic               rd_valid
);

  sle_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign fifo_full = count_r[1];
  assign rd_valid  = (count_r != 2'd0);
  assign rd_cmd    = ent_r[rd_ptr_r];

  assign do_wr = wr_en && !fifo_full;
  assign do_rd = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accepts received bytes and sorts them into store, erase and flush commands.
module sle_front (
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [sle_pkg::BYTE_W-1:0] in_rx_byte,
  input  wire logic                       fifo_full,
  output logic                            cmd_wr,
  output sle_pkg::cmd_t                   cmd
);

  assign full   = fifo_full;
  assign cmd_wr = push && !fifo_full;

  always_comb begin
    cmd.data = in_rx_byte;
    unique case (in_rx_byte)
      sle_pkg::BYTE_CR:        cmd.op = sle_pkg::OP_FLUSH;
      sle_pkg::BYTE_BACKSPACE: cmd.op = sle_pkg::OP_ERASE;
      default:                 cmd.op = sle_pkg::OP_STORE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Executes commands against the line store and presents one result word at a time.
module sle_back #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [sle_pkg::CAP_W-1:0]  cfg_data,
  input  wire logic                       cmd_valid,
  input  wire sle_pkg::cmd_t              cmd,
  output logic                            cmd_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [sle_pkg::BYTE_W-1:0] out_byte,
  output logic      [sle_pkg::KIND_W-1:0] out_kind,
  output logic                            out_last
);

  localparam int FILL_W = $clog2(LINE_DEPTH);
  localparam int DEPTH_W = $clog2(LINE_DEPTH + 1);
  localparam int LIM_W = (DEPTH_W > sle_pkg::CAP_W) ? DEPTH_W : sle_pkg::CAP_W;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(LINE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA
  } state_t;

  state_t                     state_r, state_nxt;
  logic [sle_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [FILL_W-1:0]          idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [sle_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [sle_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [LIM_W-1:0]           cap_ext, cap_clip, char_limit;
  logic                       can_store, out_fire, slot_free, ram_we;
  logic [sle_pkg::BYTE_W-1:0] ram_rdata;

  // Capacity is clipped to the store depth, and zero behaves as one.
  always_comb begin
    cap_ext  = LIM_W'(cap_r);
    cap_clip = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
    if (cap_clip == '0) begin
      cap_clip = LIM_W'(1);
    end
    char_limit = cap_clip - LIM_W'(1);
  end

  assign can_store = (LIM_W'(fill_r) < char_limit);
  assign out_fire  = out_valid_r && pop;
  assign slot_free = !out_valid_r || pop;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid && slot_free;
  assign ram_we    = cmd_pop && (cmd.op == sle_pkg::OP_STORE) && can_store;

  assign empty    = !out_valid_r;
  assign out_byte = out_byte_r;
  assign out_kind = out_kind_r;
  assign out_last = out_last_r;

  sle_ram #(
    .WIDTH(sle_pkg::BYTE_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r),
    .wdata(cmd.data),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_we ? cfg_data : cap_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          unique case (cmd.op)
            sle_pkg::OP_STORE: begin
              if (can_store) begin
                fill_nxt      = fill_r + FILL_W'(1);
                out_valid_nxt = 1'b1;
                out_byte_nxt  = cmd.data;
                out_kind_nxt  = sle_pkg::KIND_ECHO;
                out_last_nxt  = 1'b1;
              end
            end
            sle_pkg::OP_ERASE: begin
              if (fill_r != '0) begin
                fill_nxt      = fill_r - FILL_W'(1);
                out_valid_nxt = 1'b1;
                out_byte_nxt  = sle_pkg::BYTE_BACKSPACE;
                out_kind_nxt  = sle_pkg::KIND_ECHO;
                out_last_nxt  = 1'b1;
              end
            end
            sle_pkg::OP_FLUSH: begin
              idx_nxt   = '0;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        // The read address is idx; its data is ready in the next cycle.
        if (slot_free) begin
          if (idx_r != fill_r) begin
            state_nxt = ST_DATA;
          end else begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = sle_pkg::BYTE_NUL;
            out_kind_nxt  = sle_pkg::KIND_TERM;
            out_last_nxt  = 1'b1;
            fill_nxt      = '0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        // The output slot was free when the read was issued and nothing has filled it since.
        out_valid_nxt = 1'b1;
        out_byte_nxt  = ram_rdata;
        out_kind_nxt  = sle_pkg::KIND_CHAR;
        out_last_nxt  = 1'b0;
        idx_nxt       = idx_r + FILL_W'(1);
        state_nxt     = ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= sle_pkg::CAP_RESET;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sle_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_line_editor_defines.svh"

module sle_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [sle_pkg::BYTE_W-1:0] out_byte,
  input wire logic [sle_pkg::KIND_W-1:0] out_kind,
  input wire logic                       out_last
);

  // Nothing may be offered in the first cycle after reset is released.
  `SLE_ASSERT_NOW(a_empty_after_reset, !$past(rst_n), empty, "result offered straight after reset")

  `SLE_ASSERT_NOW(a_term_is_last_nul, !empty && out_kind == sle_pkg::KIND_TERM,
    out_last && out_byte == sle_pkg::BYTE_NUL, "terminator not a zero last word")

  `SLE_ASSERT_NOW(a_char_not_last, !empty && out_kind == sle_pkg::KIND_CHAR, !out_last,
    "line character marked last")

  `SLE_ASSERT_NEXT(a_stall_holds, !empty && !pop,
    !empty && $stable(out_byte) && $stable(out_kind) && $stable(out_last),
    "stalled result word changed")

endmodule

bind serial_line_editor sle_checker u_sle_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_byte(out_byte),
  .out_kind(out_kind),
  .out_last(out_last)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int HELD_MAX = sle_pkg::LINE_DEPTH_DEF;
  // Allows for a carriage return on a full line, whose characters are read out one by one.
  localparam int SETTLE_CYCLES = 2 * HELD_MAX + 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [sle_pkg::BYTE_W-1:0] data;
    logic [sle_pkg::KIND_W-1:0] kind;
    logic                       last;
  } edit_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       push = 1'b0;
  logic [sle_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                       pop = 1'b0;
  logic                       valid = 1'b0;
  logic [sle_pkg::CAP_W-1:0]  cfg_line_capacity = '0;
  logic                       full;
  logic                       empty;
  logic                       ready;
  logic [sle_pkg::BYTE_W-1:0] out_byte;
  logic [sle_pkg::KIND_W-1:0] out_kind;
  logic                       out_last;

  serial_line_editor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_rx_byte        (in_rx_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_last          (out_last),
    .valid             (valid),
    .ready             (ready),
    .cfg_line_capacity (cfg_line_capacity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the editor's line and capacity register.
  logic [sle_pkg::CAP_W-1:0]  capacity_now = sle_pkg::CAP_RESET;
  logic [sle_pkg::BYTE_W-1:0] held_chars [HELD_MAX];
  int unsigned                held_count = 0;

  edit_word_t                 expected_words [$];
  logic [sle_pkg::BYTE_W-1:0] pending_bytes [$];

  int unsigned bytes_taken = 0;
  int unsigned words_checked = 0;
  int unsigned lines_done = 0;
  int unsigned mismatches = 0;
  int unsigned caps_written = 0;
  int unsigned cycle_count = 0;

  function automatic void edit_line(input logic [sle_pkg::BYTE_W-1:0] rx);
    int unsigned keep;
    if (rx == sle_pkg::BYTE_CR) begin
      for (int i = 0; i < held_count; i++) begin
        expected_words.push_back('{held_chars[i], sle_pkg::KIND_CHAR, 1'b0});
      end
      expected_words.push_back('{sle_pkg::BYTE_NUL, sle_pkg::KIND_TERM, 1'b1});
      held_count = 0;
      lines_done++;
    end else if (rx == sle_pkg::BYTE_BACKSPACE) begin
      if (held_count != 0) begin
        held_count--;
        expected_words.push_back('{sle_pkg::BYTE_BACKSPACE, sle_pkg::KIND_ECHO, 1'b1});
      end
    end else begin
      // Capacity 0 behaves as 1, and anything above the store depth is clipped.
      keep = (capacity_now > HELD_MAX) ? HELD_MAX : ((capacity_now == 0) ? 1 : capacity_now);
      if (held_count < keep - 1) begin
        held_chars[held_count] = rx;
        held_count++;
        expected_words.push_back('{rx, sle_pkg::KIND_ECHO, 1'b1});
      end
    end
  endfunction

  // Sender: bytes go out in bursts with random gaps between them.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    logic drive;
    drive = 1'b0;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        edit_line(in_rx_byte);
        void'(pending_bytes.pop_front());
        bytes_taken++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (push && full) begin
        drive = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        drive = 1'b1;
      end
      push <= drive;
      if (drive) begin
        in_rx_byte <= pending_bytes[0];
      end
    end
  end

  // Receiver: pop follows an eight-bit pattern that is redrawn each time round.
  logic [7:0]  stall_pattern = 8'hFF;
  int unsigned stall_pos = 0;

  always @(posedge clk) begin
    edit_word_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: byte %h kind %0d last %b", out_byte, out_kind, out_last);
          end
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_byte !== want.data || out_kind !== want.kind || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on word %0d: expected byte %h kind %0d last %b, got %h %0d %b",
                       words_checked, want.data, want.kind, want.last,
                       out_byte, out_kind, out_last);
            end
          end
        end
      end
      pop <= stall_pattern[stall_pos];
      if (stall_pos == 7) begin
        stall_pos = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        stall_pos++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d words outstanding",
               CYCLE_LIMIT, expected_words.size());
      $display("serial_line_editor test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (pending_bytes.size() != 0 || expected_words.size() != 0);
  endtask

  // Dropped bytes give no word, so the editor is given time to finish before the write.
  task automatic write_capacity(input logic [sle_pkg::CAP_W-1:0] cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    valid <= 1'b1;
    cfg_line_capacity <= cap;
    @(posedge clk);
    while (!ready) @(posedge clk);
    valid <= 1'b0;
    capacity_now = cap;
    caps_written++;
  endtask

  task automatic queue_line(input int unsigned len, input bit with_erase);
    logic [sle_pkg::BYTE_W-1:0] ch;
    for (int unsigned i = 0; i < len; i++) begin
      if (with_erase && $urandom_range(0, 7) == 0) begin
        ch = sle_pkg::BYTE_BACKSPACE;
      end else begin
        do ch = 8'($urandom_range(0, 255));
        while (ch == sle_pkg::BYTE_CR || ch == sle_pkg::BYTE_BACKSPACE);
      end
      pending_bytes.push_back(ch);
    end
    pending_bytes.push_back(sle_pkg::BYTE_CR);
  endtask

  task automatic random_phase(input logic [sle_pkg::CAP_W-1:0] cap, input int unsigned budget,
                              input bit long_line);
    int unsigned added;
    int unsigned n0;
    int unsigned pick;
    bit          paused;
    added = 0;
    paused = 1'b0;
    write_capacity(cap);
    if (long_line) begin
      queue_line(HELD_MAX + 6, 1'b0);
      added = HELD_MAX + 7;
    end
    while (added < budget) begin
      n0 = pending_bytes.size();
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_line($urandom_range(0, 12), 1'b1);
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) pending_bytes.push_back(sle_pkg::BYTE_BACKSPACE);
      end
      added += pending_bytes.size() - n0;
      // Halfway through, the sender holds off until the editor has caught up.
      if (!paused && added >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: terminator alone, erase on an empty line, extreme byte values.
    pending_bytes = '{sle_pkg::BYTE_CR, sle_pkg::BYTE_BACKSPACE, 8'h00, 8'hFF, 8'h41,
                      sle_pkg::BYTE_BACKSPACE, 8'h7F, 8'h80, sle_pkg::BYTE_CR};
    // One character fits; the next is dropped silently.
    write_capacity(7'd2);
    pending_bytes = '{8'h55, 8'hAA, sle_pkg::BYTE_CR};
    // Capacity lowered below what is already held.
    write_capacity(7'd64);
    pending_bytes = '{8'h31, 8'h32, 8'h33};
    write_capacity(7'd2);
    pending_bytes = '{8'h34, sle_pkg::BYTE_BACKSPACE, 8'h35, sle_pkg::BYTE_BACKSPACE,
                      sle_pkg::BYTE_BACKSPACE, 8'h36, sle_pkg::BYTE_CR};
    // Capacity zero keeps nothing.
    write_capacity(7'd0);
    pending_bytes = '{8'h61, sle_pkg::BYTE_CR};

    random_phase(7'd1, 18, 1'b0);
    random_phase(7'd127, 80, 1'b1);
    random_phase(7'd3, 18, 1'b0);
    random_phase(7'd65, 18, 1'b0);
    random_phase(7'd0, 18, 1'b0);
    random_phase(7'd8, 18, 1'b0);
    random_phase(7'd63, 18, 1'b0);
    random_phase(7'($urandom_range(1, 127)), 18, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d accepted bytes, %0d result words and %0d completed lines,",
             bytes_taken, words_checked, lines_done);
    $display("over %0d capacity writes spanning 0 to 127; %0d mismatches.",
             caps_written, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("serial_line_editor test passed");
    end else begin
      $display("serial_line_editor test failed");
    end
    $finish;
  end

endmodule

// ===== serial_line_editor.f =====
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_cmd_fifo.sv
rtl/core/sle_front.sv
rtl/core/sle_back.sv
rtl/core/serial_line_editor.sv
rtl/core/sle_checker.sv
test/testbench.sv
